// ===== design/isc_pkg.sv =====
// ----------------------------------------------------------------------------
// isc_pkg
// Shared widths, register indexes, datapath step codes and the control
// structs of the inverter sense conditioner.
// ----------------------------------------------------------------------------
package isc_pkg;

    // default build values
    localparam int ADC_BITS_DEF    = 12;
    localparam int CAL_SAMPLES_DEF = 64;

    // fixed-point layout
    localparam int OFS_FRAC  = 6;
    localparam int GAIN_FRAC = 16;
    localparam int CUR_SH    = GAIN_FRAC + OFS_FRAC;
    localparam int OUT_W     = 16;
    localparam int TEMP_W    = 11;
    localparam int TEMP_MAX  = 2000;
    localparam int FILT_W    = 24;
    localparam int FILT_FRAC = 8;

    // shared multiplier
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADC_W  = 12;
    localparam int GAIN_W     = 16;
    localparam int OFS_RST    = 2048;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_DEFAULT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EMA_ALPHA      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_ZERO      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_GAIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VBUS_GAIN      = 3'd5;

    // configuration register file contents
    typedef struct packed {
        logic [CFG_ADC_W-1:0] offset_default;
        logic [GAIN_W-1:0]    current_gain;
        logic [GAIN_W-1:0]    ema_alpha;
        logic [CFG_ADC_W-1:0] temp_zero_counts;
        logic [GAIN_W-1:0]    temp_gain;
        logic [GAIN_W-1:0]    vbus_gain;
    } cfg_t;

    // datapath step selected by the controller
    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_CAPTURE,
        STEP_TEMP,
        STEP_VBUS,
        STEP_CUR,
        STEP_FILT,
        STEP_FUPD,
        STEP_CAL,
        STEP_DIV,
        STEP_EMIT
    } step_t;

    typedef struct packed {
        step_t step;
    } isc_cmd_t;

    typedef struct packed {
        logic op;
        logic filt_loaded;
        logic cal_last;
        logic out_free;
    } isc_status_t;

endpackage

// ===== design/isc_if.sv =====
// ----------------------------------------------------------------------------
// isc channel interfaces
// Valid/ready channels for sample triples, results and register writes.
// ----------------------------------------------------------------------------
interface isc_in_if import isc_pkg::*; #(
    parameter int ADC_BITS = ADC_BITS_DEF
) ();
    logic                valid;
    logic                ready;
    logic                operation;
    logic [ADC_BITS-1:0] adc_current;
    logic [ADC_BITS-1:0] adc_temp;
    logic [ADC_BITS-1:0] adc_vbus;

    modport source (output valid, output operation, output adc_current,
                    output adc_temp, output adc_vbus, input ready);
    modport sink   (input valid, input operation, input adc_current,
                    input adc_temp, input adc_vbus, output ready);
endinterface

interface isc_out_if import isc_pkg::*; #(
    parameter int OFS_W = CFG_ADC_W + OFS_FRAC
) ();
    logic              valid;
    logic              ready;
    logic [OUT_W-1:0]  current_now;
    logic [OUT_W-1:0]  current_smoothed;
    logic [TEMP_W-1:0] temperature;
    logic [OUT_W-1:0]  bus_voltage;
    logic [OFS_W-1:0]  offset_now;
    logic              calibration_done;

    modport source (output valid, output current_now, output current_smoothed,
                    output temperature, output bus_voltage, output offset_now,
                    output calibration_done, input ready);
    modport sink   (input valid, input current_now, input current_smoothed,
                    input temperature, input bus_voltage, input offset_now,
                    input calibration_done, output ready);
endinterface

interface isc_cfg_if import isc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/isc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// isc_cfg_regs
// Configuration register file; always ready, unknown indexes are dropped.
// ----------------------------------------------------------------------------
module isc_cfg_regs import isc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    isc_cfg_if.sink  cfg,
    output cfg_t     regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // register write decode
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_OFFSET_DEFAULT: regs_next.offset_default   = cfg.data[CFG_ADC_W-1:0];
                REG_CURRENT_GAIN:   regs_next.current_gain     = cfg.data[GAIN_W-1:0];
                REG_EMA_ALPHA:      regs_next.ema_alpha        = cfg.data[GAIN_W-1:0];
                REG_TEMP_ZERO:      regs_next.temp_zero_counts = cfg.data[CFG_ADC_W-1:0];
                REG_TEMP_GAIN:      regs_next.temp_gain        = cfg.data[GAIN_W-1:0];
                REG_VBUS_GAIN:      regs_next.vbus_gain        = cfg.data[GAIN_W-1:0];
                default:            regs_next = regs_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.offset_default   <= CFG_ADC_W'(OFS_RST);
            regs_reg.current_gain     <= GAIN_W'(256);
            regs_reg.ema_alpha        <= GAIN_W'(6554);
            regs_reg.temp_zero_counts <= CFG_ADC_W'(620);
            regs_reg.temp_gain        <= GAIN_W'(2048);
            regs_reg.vbus_gain        <= GAIN_W'(4096);
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ===== design/isc_ctrl.sv =====
// ----------------------------------------------------------------------------
// isc_ctrl
// Sequencer that walks one sample triple through the datapath steps.
// ----------------------------------------------------------------------------
module isc_ctrl import isc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  isc_status_t status,
    output isc_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TEMP = 4'd1;
    localparam logic [3:0] S_VBUS = 4'd2;
    localparam logic [3:0] S_CUR  = 4'd3;
    localparam logic [3:0] S_FILT = 4'd4;
    localparam logic [3:0] S_FUPD = 4'd5;
    localparam logic [3:0] S_CAL  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and step command
    always_comb
    begin
        state_next = state_reg;
        cmd.step   = STEP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.step   = STEP_CAPTURE;
                    state_next = S_TEMP;
                end
            end
            S_TEMP:
            begin
                cmd.step   = STEP_TEMP;
                state_next = S_VBUS;
            end
            S_VBUS:
            begin
                cmd.step   = STEP_VBUS;
                state_next = status.op ? S_CAL : S_CUR;
            end
            S_CUR:
            begin
                cmd.step   = STEP_CUR;
                state_next = S_FILT;
            end
            S_FILT:
            begin
                cmd.step   = STEP_FILT;
                state_next = status.filt_loaded ? S_FUPD : S_EMIT;
            end
            S_FUPD:
            begin
                cmd.step   = STEP_FUPD;
                state_next = S_EMIT;
            end
            S_CAL:
            begin
                cmd.step   = STEP_CAL;
                state_next = status.cal_last ? S_DIV : S_EMIT;
            end
            S_DIV:
            begin
                cmd.step   = STEP_DIV;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.step   = STEP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/isc_datapath.sv =====
// ----------------------------------------------------------------------------
// isc_datapath
// Shared multiplier, offset and calibration state, moving average filter,
// reciprocal-multiply mean of a calibration run and the output register.
// ----------------------------------------------------------------------------
module isc_datapath import isc_pkg::*; #(
    parameter int ADC_BITS    = ADC_BITS_DEF,
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF,
    parameter int OFS_W       = ((ADC_BITS > CFG_ADC_W) ? ADC_BITS : CFG_ADC_W) + OFS_FRAC
) (
    input  logic                clk,
    input  logic                rst_n,
    input  isc_cmd_t            cmd,
    output isc_status_t         status,
    input  cfg_t                cfg,
    input  logic                operation,
    input  logic [ADC_BITS-1:0] adc_current,
    input  logic [ADC_BITS-1:0] adc_temp,
    input  logic [ADC_BITS-1:0] adc_vbus,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [OUT_W-1:0]    current_now,
    output logic [OUT_W-1:0]    current_smoothed,
    output logic [TEMP_W-1:0]   temperature,
    output logic [OUT_W-1:0]    bus_voltage,
    output logic [OFS_W-1:0]    offset_now,
    output logic                calibration_done
);

    localparam int ACC_W   = ADC_BITS + $clog2(CAL_SAMPLES);
    localparam int CNT_W   = $clog2(CAL_SAMPLES);
    localparam int DIV_W   = ACC_W + OFS_FRAC;
    localparam int MEAN_W  = ADC_BITS + OFS_FRAC;
    localparam int RCP_SH  = DIV_W + $clog2(CAL_SAMPLES);
    localparam int RCP_W   = DIV_W + 1;
    localparam int MPROD_W = DIV_W + RCP_W;

    // rounded-up reciprocal of the run length, exact for any dividend below 2^DIV_W
    localparam logic [RCP_W-1:0] RCP_M =
        RCP_W'(((64'd1 << RCP_SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

    // captured item and intermediate results
    logic                op_reg, op_next;
    logic [ADC_BITS-1:0] rc_reg, rc_next;
    logic [ADC_BITS-1:0] rt_reg, rt_next;
    logic [ADC_BITS-1:0] rv_reg, rv_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [TEMP_W-1:0]   temp_res_reg, temp_res_next;
    logic [OUT_W-1:0]    vbus_res_reg, vbus_res_next;
    logic [OUT_W-1:0]    cur_now_reg, cur_now_next;
    logic                neg_reg, neg_next;
    logic [DIV_W-1:0]    div_num_reg, div_num_next;

    // persistent state
    logic [OFS_W-1:0]    offset_reg, offset_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                loaded_reg, loaded_next;
    logic [FILT_W-1:0]   filt_reg, filt_next;
    logic                done_reg, done_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]    o_cur_reg, o_cur_next;
    logic [OUT_W-1:0]    o_smooth_reg, o_smooth_next;
    logic [TEMP_W-1:0]   o_temp_reg, o_temp_next;
    logic [OUT_W-1:0]    o_vbus_reg, o_vbus_next;
    logic [OFS_W-1:0]    o_ofs_reg, o_ofs_next;
    logic                o_done_reg, o_done_next;

    // helpers
    logic [OFS_W-1:0]    ofs_def_w;
    logic [ADC_BITS-1:0] zero_m;
    logic [ADC_BITS-1:0] temp_above;
    logic [OFS_W-1:0]    scaled;
    logic [OFS_W-1:0]    delta;
    logic [OUT_W-1:0]    p_q16;
    logic                p_hi16;
    logic [TEMP_W-1:0]   temp_clamp;
    logic [OUT_W-1:0]    vbus_sat;
    logic [OUT_W-1:0]    cur_sat;
    logic [FILT_W-1:0]   x_w;
    logic [FILT_W-1:0]   diff;
    logic [FILT_W-1:0]   filt_step;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [ACC_W-1:0]    acc_add;
    logic [DIV_W-1:0]    dividend;
    logic [MPROD_W-1:0]  mean_prod;
    logic [MEAN_W-1:0]   mean_q;

    // offset, temperature and current correction
    assign ofs_def_w  = OFS_W'(ADC_BITS'(cfg.offset_default)) << OFS_FRAC;
    assign zero_m     = ADC_BITS'(cfg.temp_zero_counts);
    assign temp_above = (rt_reg > zero_m) ? (rt_reg - zero_m) : '0;
    assign scaled     = OFS_W'(rc_reg) << OFS_FRAC;
    assign delta      = (scaled > offset_reg) ? (scaled - offset_reg) : '0;

    // product slices and saturation
    assign p_q16      = prod_reg[GAIN_FRAC+OUT_W-1:GAIN_FRAC];
    assign p_hi16     = |prod_reg[PROD_W-1:GAIN_FRAC+OUT_W];
    assign temp_clamp = (p_hi16 || (p_q16 > OUT_W'(TEMP_MAX))) ? TEMP_W'(TEMP_MAX)
                                                             : p_q16[TEMP_W-1:0];
    assign vbus_sat   = p_hi16 ? '1 : p_q16;
    assign cur_sat    = (|prod_reg[PROD_W-1:CUR_SH+OUT_W]) ? '1
                                                           : prod_reg[CUR_SH+OUT_W-1:CUR_SH];

    // filter difference and step
    assign x_w       = {cur_sat, {FILT_FRAC{1'b0}}};
    assign diff      = (x_w >= filt_reg) ? (x_w - filt_reg) : (filt_reg - x_w);
    assign filt_step = prod_reg[GAIN_FRAC+FILT_W-1:GAIN_FRAC];

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.step)
            STEP_TEMP:
            begin
                mul_a = MUL_A_W'(temp_above);
                mul_b = cfg.temp_gain;
            end
            STEP_VBUS:
            begin
                mul_a = MUL_A_W'(rv_reg);
                mul_b = cfg.vbus_gain;
            end
            STEP_CUR:
            begin
                mul_a = MUL_A_W'(delta);
                mul_b = cfg.current_gain;
            end
            STEP_FILT:
            begin
                mul_a = diff;
                mul_b = cfg.ema_alpha;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

    // calibration accumulate and mean of the run
    assign acc_add   = ((cnt_reg == '0) ? '0 : acc_reg) + ACC_W'(rc_reg);
    assign dividend  = DIV_W'(acc_add) << OFS_FRAC;
    assign mean_prod = {{RCP_W{1'b0}}, div_num_reg} * {{DIV_W{1'b0}}, RCP_M};
    assign mean_q    = mean_prod[RCP_SH +: MEAN_W];

    // status to the controller
    assign status.op          = op_reg;
    assign status.filt_loaded = loaded_reg;
    assign status.cal_last    = (cnt_reg == CNT_W'(CAL_SAMPLES - 1));
    assign status.out_free    = !out_valid_reg || out_ready;

    // step execution
    always_comb
    begin
        op_next        = op_reg;
        rc_next        = rc_reg;
        rt_next        = rt_reg;
        rv_next        = rv_reg;
        temp_res_next  = temp_res_reg;
        vbus_res_next  = vbus_res_reg;
        cur_now_next   = cur_now_reg;
        neg_next       = neg_reg;
        div_num_next   = div_num_reg;
        offset_next    = offset_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        loaded_next    = loaded_reg;
        filt_next      = filt_reg;
        done_next      = done_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        o_cur_next     = o_cur_reg;
        o_smooth_next  = o_smooth_reg;
        o_temp_next    = o_temp_reg;
        o_vbus_next    = o_vbus_reg;
        o_ofs_next     = o_ofs_reg;
        o_done_next    = o_done_reg;
        unique case (cmd.step)
            STEP_CAPTURE:
            begin
                op_next      = operation;
                rc_next      = adc_current;
                rt_next      = adc_temp;
                rv_next      = adc_vbus;
                cur_now_next = '0;
                done_next    = 1'b0;
            end
            STEP_VBUS:
            begin
                temp_res_next = temp_clamp;
            end
            STEP_CUR:
            begin
                vbus_res_next = vbus_sat;
                acc_next      = '0;
                cnt_next      = '0;
            end
            STEP_FILT:
            begin
                cur_now_next = cur_sat;
                if (!loaded_reg)
                begin
                    filt_next   = x_w;
                    loaded_next = 1'b1;
                end
                else
                begin
                    neg_next = (x_w < filt_reg);
                end
            end
            STEP_FUPD:
            begin
                filt_next = neg_reg ? (filt_reg - filt_step) : (filt_reg + filt_step);
            end
            STEP_CAL:
            begin
                vbus_res_next = vbus_sat;
                acc_next      = acc_add;
                if (cnt_reg == '0)
                begin
                    offset_next = ofs_def_w;
                end
                if (status.cal_last)
                begin
                    cnt_next     = '0;
                    div_num_next = dividend;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            STEP_DIV:
            begin
                offset_next = OFS_W'(mean_q);
                acc_next    = '0;
                cnt_next    = '0;
                loaded_next = 1'b0;
                filt_next   = '0;
                done_next   = 1'b1;
            end
            STEP_EMIT:
            begin
                out_valid_next = 1'b1;
                o_cur_next     = cur_now_reg;
                o_smooth_next  = op_reg ? '0 : filt_reg[FILT_W-1:FILT_FRAC];
                o_temp_next    = temp_res_reg;
                o_vbus_next    = vbus_res_reg;
                o_ofs_next     = offset_reg;
                o_done_next    = done_reg;
            end
            default:
            begin
                op_next = op_reg;
            end
        endcase
    end

    // control and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= OFS_W'(OFS_RST) << OFS_FRAC;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            loaded_reg    <= 1'b0;
            filt_reg      <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            offset_reg    <= offset_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            loaded_reg    <= loaded_next;
            filt_reg      <= filt_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        rc_reg       <= rc_next;
        rt_reg       <= rt_next;
        rv_reg       <= rv_next;
        prod_reg     <= prod_next;
        temp_res_reg <= temp_res_next;
        vbus_res_reg <= vbus_res_next;
        cur_now_reg  <= cur_now_next;
        neg_reg      <= neg_next;
        div_num_reg  <= div_num_next;
        o_cur_reg    <= o_cur_next;
        o_smooth_reg <= o_smooth_next;
        o_temp_reg   <= o_temp_next;
        o_vbus_reg   <= o_vbus_next;
        o_ofs_reg    <= o_ofs_next;
        o_done_reg   <= o_done_next;
    end

    assign out_valid        = out_valid_reg;
    assign current_now      = o_cur_reg;
    assign current_smoothed = o_smooth_reg;
    assign temperature      = o_temp_reg;
    assign bus_voltage      = o_vbus_reg;
    assign offset_now       = o_ofs_reg;
    assign calibration_done = o_done_reg;

endmodule

// ===== design/inverter_sense_conditioner.sv =====
// ----------------------------------------------------------------------------
// inverter_sense_conditioner
// Offset calibration, scaling and current smoothing of inverter ADC samples.
// ----------------------------------------------------------------------------
// Each accepted transaction carries one current, temperature and bus voltage
// sample and yields exactly one result transaction. Items are processed one
// at a time through a single shared 24x16 multiplier. A measure item passes
// the temperature, bus voltage, current and filter steps, and a filter update
// step once the moving average is loaded; a calibration sample passes the
// temperature, bus voltage and calibration steps, and the sample that
// completes a calibration run takes one step more, in which the mean offset
// is formed by a multiplication with the reciprocal of CAL_SAMPLES. Each item
// then loads the result register. A new transaction is accepted only after
// the previous result is loaded into the output register, even while that
// result still waits to be taken; a result left waiting holds the next item
// in its last step until the output register frees.
// Register writes are always accepted and take effect at once; write them
// only while no item is in flight.
module inverter_sense_conditioner import isc_pkg::*; #(
    parameter int ADC_BITS    = ADC_BITS_DEF,
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF,
    parameter int OFS_W       = ((ADC_BITS > CFG_ADC_W) ? ADC_BITS : CFG_ADC_W) + OFS_FRAC
) (
    input  logic      clk,
    input  logic      rst_n,
    isc_in_if.sink    adc_in,
    isc_out_if.source result,
    isc_cfg_if.sink   cfg
);

    cfg_t        regs;
    isc_cmd_t    cmd;
    isc_status_t status;

    // configuration registers
    isc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // sequencer
    isc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (adc_in.valid),
        .in_ready (adc_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and state
    isc_datapath #(
        .ADC_BITS    (ADC_BITS),
        .CAL_SAMPLES (CAL_SAMPLES),
        .OFS_W       (OFS_W)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg              (regs),
        .operation        (adc_in.operation),
        .adc_current      (adc_in.adc_current),
        .adc_temp         (adc_in.adc_temp),
        .adc_vbus         (adc_in.adc_vbus),
        .out_ready        (result.ready),
        .out_valid        (result.valid),
        .current_now      (result.current_now),
        .current_smoothed (result.current_smoothed),
        .temperature      (result.temperature),
        .bus_voltage      (result.bus_voltage),
        .offset_now       (result.offset_now),
        .calibration_done (result.calibration_done)
    );

endmodule

// ===== tb/sv/inverter_sense_conditioner_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverter_sense_conditioner_test
// Self-checking bench for the inverter sense conditioner. Sample triples are
// pushed in bursts under a randomly stalling result sink. A scoreboard keeps
// its own copy of the offset, calibration and filter state and checks every
// result transaction field by field. Several register settings are visited,
// the all-zero and all-one extremes among them.
// ----------------------------------------------------------------------------
module inverter_sense_conditioner_test;
    import isc_pkg::*;

    localparam int ADC_W       = ADC_BITS_DEF;
    localparam int CAL_RUN     = CAL_SAMPLES_DEF;
    localparam int OFS_BITS    = CFG_ADC_W + OFS_FRAC;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 150;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = 60;
    localparam longint TIMEOUT_NS = 6_000_000;

    localparam logic OP_MEASURE   = 1'b0;
    localparam logic OP_CALIBRATE = 1'b1;

    // indexes past the register list, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic             operation;
        logic [ADC_W-1:0] adc_current;
        logic [ADC_W-1:0] adc_temp;
        logic [ADC_W-1:0] adc_vbus;
    } sense_sample_t;

    typedef struct packed {
        logic [OUT_W-1:0]    current_now;
        logic [OUT_W-1:0]    current_smoothed;
        logic [TEMP_W-1:0]   temperature;
        logic [OUT_W-1:0]    bus_voltage;
        logic [OFS_BITS-1:0] offset_now;
        logic                calibration_done;
    } sense_result_t;

    // conditioner state mirror and queue of predicted result transactions
    class sense_scoreboard;
        cfg_t                regs;
        logic [OFS_BITS-1:0] offset_q6;
        logic [OFS_BITS-1:0] cal_sum;
        logic [7:0]          cal_seen;
        logic                filt_loaded;
        logic [FILT_W-1:0]   filt_q8;
        sense_result_t       predicted_q[$];
        int unsigned         errors;

        function new();
            regs.offset_default   = 12'd2048;
            regs.current_gain     = 16'd256;
            regs.ema_alpha        = 16'd6554;
            regs.temp_zero_counts = 12'd620;
            regs.temp_gain        = 16'd2048;
            regs.vbus_gain        = 16'd4096;
            offset_q6   = OFS_BITS'(OFS_RST) << OFS_FRAC;
            cal_sum     = '0;
            cal_seen    = '0;
            filt_loaded = 1'b0;
            filt_q8     = '0;
            errors      = 0;
        endfunction

        function int pending();
            return predicted_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_OFFSET_DEFAULT: regs.offset_default   = data[CFG_ADC_W-1:0];
                REG_CURRENT_GAIN:   regs.current_gain     = data;
                REG_EMA_ALPHA:      regs.ema_alpha        = data;
                REG_TEMP_ZERO:      regs.temp_zero_counts = data[CFG_ADC_W-1:0];
                REG_TEMP_GAIN:      regs.temp_gain        = data;
                REG_VBUS_GAIN:      regs.vbus_gain        = data;
                default: ;
            endcase
        endfunction

        // predict the result of one accepted sample transaction
        function void note_input(sense_sample_t s);
            longint unsigned rc, rt, rv, zero, above, t, v, scaled, delta, c, x, f, sum;
            sense_result_t   e;
            rc   = s.adc_current;
            rt   = s.adc_temp;
            rv   = s.adc_vbus;
            zero = regs.temp_zero_counts;

            // temperature and bus voltage are computed on every item
            above = (rt > zero) ? rt - zero : 0;
            t = (above * regs.temp_gain) >> GAIN_FRAC;
            if (t > TEMP_MAX)
                t = TEMP_MAX;
            v = (rv * regs.vbus_gain) >> GAIN_FRAC;
            if (v > 65535)
                v = 65535;

            e.current_now      = '0;
            e.current_smoothed = '0;
            e.calibration_done = 1'b0;
            e.temperature      = t[TEMP_W-1:0];
            e.bus_voltage      = v[OUT_W-1:0];

            if (s.operation == OP_MEASURE)
            begin
                // a measure item drops any unfinished calibration run
                cal_seen = '0;
                cal_sum  = '0;
                scaled = rc << OFS_FRAC;
                delta  = (scaled > offset_q6) ? scaled - offset_q6 : 0;
                c = (delta * regs.current_gain) >> CUR_SH;
                if (c > 65535)
                    c = 65535;
                x = c << FILT_FRAC;
                f = filt_q8;
                if (!filt_loaded)
                begin
                    f = x;
                    filt_loaded = 1'b1;
                end
                else if (x >= f)
                    f = f + (((x - f) * regs.ema_alpha) >> GAIN_FRAC);
                else
                    f = f - (((f - x) * regs.ema_alpha) >> GAIN_FRAC);
                filt_q8 = f[FILT_W-1:0];
                e.current_now      = c[OUT_W-1:0];
                e.current_smoothed = OUT_W'(f >> FILT_FRAC);
            end
            else
            begin
                // run start reloads the default offset
                if (cal_seen == 0)
                begin
                    offset_q6 = OFS_BITS'(regs.offset_default) << OFS_FRAC;
                    cal_sum   = '0;
                end
                sum = longint'(cal_sum) + rc;
                cal_sum  = sum[OFS_BITS-1:0];
                cal_seen = cal_seen + 1;
                if (cal_seen >= CAL_RUN)
                begin
                    offset_q6   = OFS_BITS'((sum << OFS_FRAC) / CAL_RUN);
                    cal_sum     = '0;
                    cal_seen    = '0;
                    filt_loaded = 1'b0;
                    filt_q8     = '0;
                    e.calibration_done = 1'b1;
                end
            end
            e.offset_now = offset_q6;
            predicted_q.push_back(e);
        endfunction

        // compare one result transaction against the oldest prediction
        function void check_result(sense_result_t got);
            sense_result_t e;
            if (predicted_q.size() == 0)
            begin
                $error("result transaction with no sample pending");
                errors++;
                return;
            end
            e = predicted_q.pop_front();
            if (got.current_now !== e.current_now)
            begin
                $error("current_now: expected %0d, actual %0d", e.current_now, got.current_now);
                errors++;
            end
            if (got.current_smoothed !== e.current_smoothed)
            begin
                $error("current_smoothed: expected %0d, actual %0d",
                       e.current_smoothed, got.current_smoothed);
                errors++;
            end
            if (got.temperature !== e.temperature)
            begin
                $error("temperature: expected %0d, actual %0d", e.temperature, got.temperature);
                errors++;
            end
            if (got.bus_voltage !== e.bus_voltage)
            begin
                $error("bus_voltage: expected %0d, actual %0d", e.bus_voltage, got.bus_voltage);
                errors++;
            end
            if (got.offset_now !== e.offset_now)
            begin
                $error("offset_now: expected %0d, actual %0d", e.offset_now, got.offset_now);
                errors++;
            end
            if (got.calibration_done !== e.calibration_done)
            begin
                $error("calibration_done: expected %0d, actual %0d",
                       e.calibration_done, got.calibration_done);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    isc_in_if  adc_ch ();
    isc_out_if res_ch ();
    isc_cfg_if cfg_ch ();

    sense_scoreboard sb;
    bit              gaps_on;
    bit              long_hold_req;
    int unsigned     burst_left;
    int unsigned     items_sent;

    inverter_sense_conditioner i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .adc_in (adc_ch.sink),
        .result (res_ch.source),
        .cfg    (cfg_ch.sink)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [ADC_W-1:0] clamp_adc(int v);
        if (v < 0)
            return '0;
        if (v > 4095)
            return 12'hFFF;
        return v[ADC_W-1:0];
    endfunction

    // register value for a setting phase, extremes first
    function automatic logic [CFG_DATA_W-1:0] setting_value(int unsigned phase);
        int unsigned r;
        if (phase == 0)
            return 16'hFFFF;
        if (phase == 1)
            return 16'h0000;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // one register write transaction
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    // one sample transaction, with burst gaps when enabled
    task automatic drive_sample(input logic op, input logic [ADC_W-1:0] rc,
                                input logic [ADC_W-1:0] rt, input logic [ADC_W-1:0] rv);
        sense_sample_t s;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                adc_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        s.operation   = op;
        s.adc_current = rc;
        s.adc_temp    = rt;
        s.adc_vbus    = rv;
        adc_ch.valid       <= 1'b1;
        adc_ch.operation   <= op;
        adc_ch.adc_current <= rc;
        adc_ch.adc_temp    <= rt;
        adc_ch.adc_vbus    <= rv;
        @(posedge clk);
        while (!adc_ch.ready)
            @(posedge clk);
        sb.note_input(s);
        items_sent++;
        @(negedge clk);
    endtask

    // sender stops and waits for every predicted result
    task automatic drain_results();
        int unsigned spin;
        spin = 0;
        adc_ch.valid <= 1'b0;
        while (sb.pending() != 0 && spin < DRAIN_LIMIT)
        begin
            @(negedge clk);
            spin++;
        end
        repeat (4) @(negedge clk);
    endtask

    // temperature count, uniform or around the zero point
    function automatic logic [ADC_W-1:0] pick_temp();
        if ($urandom_range(0, 2) == 0)
            return clamp_adc(int'(sb.regs.temp_zero_counts) + $urandom_range(0, 40) - 20);
        return ADC_W'($urandom);
    endfunction

    // calibration run of a given length around a random level
    task automatic send_cal_run(input int unsigned len);
        int unsigned level, spread;
        level  = $urandom_range(0, 4095);
        spread = $urandom_range(0, 3);
        for (int unsigned k = 0; k < len; k++)
        begin
            if (spread == 3)
                drive_sample(OP_CALIBRATE, ADC_W'($urandom), pick_temp(), ADC_W'($urandom));
            else
                drive_sample(OP_CALIBRATE,
                             clamp_adc(int'(level) + $urandom_range(0, 16 << (2 * spread))
                                       - (8 << (2 * spread))),
                             pick_temp(), ADC_W'($urandom));
        end
    endtask

    // measure burst, current uniform, near the offset or at the ends
    task automatic send_measures(input int unsigned len);
        int unsigned r;
        logic [ADC_W-1:0] rc;
        for (int unsigned k = 0; k < len; k++)
        begin
            r = $urandom_range(0, 3);
            if (r == 1)
                rc = clamp_adc(int'(sb.offset_q6 >> OFS_FRAC) + $urandom_range(0, 16) - 8);
            else if (r == 2)
                rc = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            else
                rc = ADC_W'($urandom);
            drive_sample(OP_MEASURE, rc, pick_temp(), ADC_W'($urandom));
        end
    endtask

    // result sink with its own stall pattern
    initial
    begin : result_sink
        int unsigned mode, mode_left, tick;
        res_ch.ready <= 1'b0;
        mode      = 0;
        mode_left = 100;
        tick      = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                // long hold so the block backs up into its input
                long_hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(30, 300);
                end
                mode_left--;
                tick++;
                case (mode)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= 1'($urandom_range(0, 1));
                    2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: res_ch.ready <= ((tick % 7) < 3);
                endcase
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : result_monitor
        sense_result_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.current_now      = res_ch.current_now;
            got.current_smoothed = res_ch.current_smoothed;
            got.temperature      = res_ch.temperature;
            got.bus_voltage      = res_ch.bus_voltage;
            got.offset_now       = res_ch.offset_now;
            got.calibration_done = res_ch.calibration_done;
            sb.check_result(got);
        end
    end

    // stimulus
    initial
    begin : stimulus
        int unsigned kind, target;
        sb            = new();
        gaps_on       = 1'b0;
        long_hold_req = 1'b0;
        burst_left    = 0;
        items_sent    = 0;
        rst_n = 1'b0;
        adc_ch.valid       <= 1'b0;
        adc_ch.operation   <= OP_MEASURE;
        adc_ch.adc_current <= '0;
        adc_ch.adc_temp    <= '0;
        adc_ch.adc_vbus    <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_OFFSET_DEFAULT;
        cfg_ch.data  <= '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // directed items under reset settings
        // current equal to offset, first measure loads the filter
        drive_sample(OP_MEASURE, 12'd2048, 12'd620, 12'd0);
        // full scale on every input
        drive_sample(OP_MEASURE, 12'hFFF, 12'hFFF, 12'hFFF);
        // current below offset, temperature below zero, filter falls
        drive_sample(OP_MEASURE, 12'h000, 12'h000, 12'h000);
        drive_sample(OP_MEASURE, 12'd3000, 12'd1500, 12'd2000);
        // filter rises
        drive_sample(OP_MEASURE, 12'hFFF, 12'd2000, 12'hFFF);
        // partial calibration run then abandoned
        drive_sample(OP_CALIBRATE, 12'h000, 12'h555, 12'hAAA);
        drive_sample(OP_CALIBRATE, 12'hFFF, 12'hAAA, 12'h555);
        drive_sample(OP_CALIBRATE, 12'hAAA, 12'd619, 12'd1);
        drive_sample(OP_CALIBRATE, 12'h555, 12'd621, 12'd2);
        drive_sample(OP_MEASURE, 12'h555, 12'hAAA, 12'h555);
        drive_sample(OP_MEASURE, 12'hAAA, 12'h555, 12'hAAA);
        // one-sample run restarts from the default offset
        drive_sample(OP_CALIBRATE, 12'd100, 12'd700, 12'd3000);
        drive_sample(OP_MEASURE, 12'd2047, 12'd621, 12'd1);
        drive_sample(OP_MEASURE, 12'd2049, 12'd619, 12'd2);
        drive_sample(OP_MEASURE, 12'd1024, 12'd3000, 12'd3000);

        // random phases, each under a fresh register setting
        for (int unsigned phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            write_register(REG_OFFSET_DEFAULT, setting_value(phase));
            write_register(REG_CURRENT_GAIN, setting_value(phase));
            write_register(REG_EMA_ALPHA, setting_value(phase));
            write_register(REG_TEMP_ZERO, setting_value(phase));
            write_register(REG_TEMP_GAIN, setting_value(phase));
            write_register(REG_VBUS_GAIN, setting_value(phase));
            write_register(REG_SPARE_LO, 16'($urandom));
            write_register(REG_SPARE_HI, 16'($urandom));
            cfg_ch.valid <= 1'b0;
            gaps_on    = (phase % 3 != 1);
            burst_left = 0;
            if (phase == 3)
                long_hold_req = 1'b1;

            // every phase opens with a complete calibration run
            target = items_sent + PHASE_ITEMS;
            send_cal_run(CAL_RUN);
            while (items_sent < target)
            begin
                kind = $urandom_range(0, 9);
                if (kind == 0)
                    send_cal_run(CAL_RUN);
                else if (kind == 1)
                    send_cal_run($urandom_range(1, CAL_RUN - 1));
                else
                    send_measures($urandom_range(1, 24));
            end
        end

        // drain and report
        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d result transactions never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/isc_pkg.sv
design/isc_if.sv
design/isc_cfg_regs.sv
design/isc_ctrl.sv
design/isc_datapath.sv
design/inverter_sense_conditioner.sv
tb/sv/inverter_sense_conditioner_test.sv
